// ----- design/assert_macros.svh -----
// Assertion macros used by the timer bank RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OTB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank assertion failed");
`define OTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank assertion failed");
`else
`define OTB_ASSERT_IMPL(label, ante, cons)
`define OTB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/otb_pkg.sv -----
// Package for the one-shot timer bank: sizes, action codes, word structs.
// No dependencies.
package otb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int MASK_W      = 8;
    localparam int ACTION_W    = 3;
    localparam int INDEX_W     = 3;
    localparam int COUNT_W     = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_RESET = 3'd3,
        ACT_QUERY = 3'd4
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  timer_index;
        logic [COUNT_W-1:0]  elapsed;
    } cmd_t;

    typedef struct packed {
        logic              selected_done;
        logic [MASK_W-1:0] done_mask;
        logic [MASK_W-1:0] running_mask;
    } result_t;

endpackage

// ----- design/multi_channel_oneshot_timer_bank.sv -----
// An accepted word is processed once the result register is free; the result is then registered.
// Throughput: one word per cycle while results are taken; all timers update in parallel in a single pass.
// The input register can still take one word while a result waits to be taken.
// Reset (async, active low): all timers idle, counts zero, limits 65535, both sides empty.
// Depends on otb_pkg and otb_timer_core.
module multi_channel_oneshot_timer_bank (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [otb_pkg::ACTION_W-1:0]   action,
    input  logic [otb_pkg::INDEX_W-1:0]    timer_index,
    input  logic [otb_pkg::COUNT_W-1:0]    elapsed,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           selected_done,
    output logic [otb_pkg::MASK_W-1:0]     done_mask,
    output logic [otb_pkg::MASK_W-1:0]     running_mask,
    input  logic                           cfg_we,
    input  logic [otb_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [otb_pkg::COUNT_W-1:0]    cfg_data
);
    import otb_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    cmd_t    cmd_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    out_free;
    logic    step;
    logic    in_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    assign in_valid_next  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    otb_timer_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (step),
        .cmd       (cmd_reg),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg.action      <= action;
            cmd_reg.timer_index <= timer_index;
            cmd_reg.elapsed     <= elapsed;
        end
        if (step)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign selected_done = res_reg.selected_done;
    assign done_mask     = res_reg.done_mask;
    assign running_mask  = res_reg.running_mask;

endmodule

// ----- design/otb_timer_core.sv -----
// Timer state, limit registers and the combinational update of all timers in parallel.
// Depends on otb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module otb_timer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [otb_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [otb_pkg::COUNT_W-1:0]    cfg_data,
    input  logic                           step_en,
    input  otb_pkg::cmd_t                  cmd,
    output otb_pkg::result_t               result
);
    import otb_pkg::*;

    logic [COUNT_W-1:0]     limit_reg [TIMER_COUNT];
    logic [COUNT_W-1:0]     count_reg [TIMER_COUNT];
    logic [COUNT_W-1:0]     count_next [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] running_reg;
    logic [TIMER_COUNT-1:0] running_next;
    logic [TIMER_COUNT-1:0] done_reg;
    logic [TIMER_COUNT-1:0] done_next;
    logic [TIMER_COUNT-1:0] hit;
    logic [COUNT_W:0]       sum [TIMER_COUNT];
    logic                   sel_done;

    always_comb
    begin
        running_next = running_reg;
        done_next    = done_reg;
        sel_done     = 1'b0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            count_next[i] = count_reg[i];
            hit[i]        = (cmd.timer_index == INDEX_W'(i));
            sum[i]        = {1'b0, count_reg[i]} + {1'b0, cmd.elapsed};
            if (step_en)
            begin
                case (cmd.action)
                    ACT_TICK:
                    begin
                        if (running_reg[i])
                        begin
                            if (sum[i] >= {1'b0, limit_reg[i]})
                            begin
                                running_next[i] = 1'b0;
                                done_next[i]    = 1'b1;
                                count_next[i]   = '0;
                            end
                            else
                            begin
                                count_next[i] = sum[i][COUNT_W-1:0];
                            end
                        end
                    end
                    ACT_START:
                    begin
                        if (hit[i])
                            running_next[i] = 1'b1;
                    end
                    ACT_STOP:
                    begin
                        if (hit[i])
                        begin
                            running_next[i] = 1'b0;
                            done_next[i]    = 1'b0;
                        end
                    end
                    ACT_RESET:
                    begin
                        if (hit[i])
                        begin
                            running_next[i] = 1'b0;
                            done_next[i]    = 1'b0;
                            count_next[i]   = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (hit[i] && done_next[i])
                sel_done = 1'b1;
        end
        result.selected_done = sel_done;
        result.done_mask     = MASK_W'(done_next);
        result.running_mask  = MASK_W'(running_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            done_reg    <= '0;
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                count_reg[i] <= '0;
                limit_reg[i] <= '1;
            end
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                count_reg[i] <= count_next[i];
                if (cfg_we && cfg_index == INDEX_W'(i))
                    limit_reg[i] <= cfg_data;
            end
        end
    end

    // query leaves every flag alone; unused codes do too but are not asserted here
    `OTB_ASSERT_NEXT(a_query_keeps_flags, step_en && cmd.action == ACT_QUERY, $stable(running_reg) && $stable(done_reg))
    // a tick can only stop timers, never start one
    `OTB_ASSERT_NEXT(a_tick_no_start, step_en && cmd.action == ACT_TICK, (running_reg & ~$past(running_reg)) == '0)
    // commands touch at most the addressed timer
    `OTB_ASSERT_NEXT(a_cmd_one_timer, step_en && cmd.action != ACT_TICK, $countones(running_reg ^ $past(running_reg)) <= 1 && $countones(done_reg ^ $past(done_reg)) <= 1)
    // no step, no change
    `OTB_ASSERT_NEXT(a_idle_hold, !step_en, $stable(running_reg) && $stable(done_reg))

endmodule
